// ----- rtl/gn_pkg.sv -----
package gn_pkg;

  localparam int MAX_GROUP_ELEMS_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // widest address and count any legal group size needs
  localparam int ADDR_W_MAX = 16;
  localparam int CNT_W_MAX  = 17;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 12;
  localparam int EPS_W     = 16;
  localparam int SCALE_W   = 24;
  localparam int OFFSET_W  = 32;

  localparam logic [EPS_W-1:0] EPS_RESET    = 16'd66;
  localparam logic             AFFINE_RESET = 1'b1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // register select is paddr[2]
  localparam logic REG_EPSILON = 1'b0;
  localparam logic REG_AFFINE  = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic [INDEX_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] gamma;
    logic signed [SAMPLE_W-1:0] beta;
  } req_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [1:0]                 status;
  } rsp_word_t;

  // classified command between front and back
  typedef struct packed {
    logic                       op;
    logic                       new_group;
    logic                       drop;
    logic                       last;
    logic [ADDR_W_MAX-1:0]      addr;
    logic [CNT_W_MAX-1:0]       count;
    logic [1:0]                 status;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] gamma;
    logic signed [SAMPLE_W-1:0] beta;
  } gn_cmd_t;

endpackage

// ----- rtl/gn_front.sv -----
module gn_front #(
  parameter int MAX_GROUP_ELEMS = gn_pkg::MAX_GROUP_ELEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  gn_pkg::req_word_t req_word,
  input  logic              q_full,
  output logic              q_push,
  output gn_pkg::gn_cmd_t   q_cmd
);
  import gn_pkg::*;

  localparam int CW = $clog2(MAX_GROUP_ELEMS + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_GROUP_ELEMS);

  // front's view of the group after every queued word
  logic [CW-1:0] count, count_next, base;
  logic          ready_flag, ready_flag_next;
  logic [IW-1:0] idx_ext, cnt_ext;

  assign req_ready = !q_full;
  assign q_push    = req_valid && !q_full;

  always_comb begin
    base            = ready_flag ? '0 : count;
    idx_ext         = IW'(req_word.index);
    cnt_ext         = IW'(count);
    count_next      = count;
    ready_flag_next = ready_flag;
    q_cmd           = '0;
    q_cmd.op        = req_word.op;
    q_cmd.sample    = req_word.sample;
    q_cmd.gamma     = req_word.gamma;
    q_cmd.beta      = req_word.beta;
    q_cmd.status    = ST_OK;
    if (req_word.op == OP_PUSH) begin
      q_cmd.new_group = ready_flag;
      q_cmd.drop      = (base == CAP);
      q_cmd.addr      = ADDR_W_MAX'(base);
      count_next      = (base == CAP) ? base : base + 1'b1;
      q_cmd.count     = CNT_W_MAX'(count_next);
      q_cmd.last      = req_word.last;
      ready_flag_next = req_word.last;
    end else begin
      q_cmd.addr = ADDR_W_MAX'(req_word.index);
      if (!ready_flag) begin
        q_cmd.status = ST_NOT_READY;
      end else if (idx_ext >= cnt_ext) begin
        q_cmd.status = ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ready_flag <= 1'b0;
    end else if (q_push) begin
      count      <= count_next;
      ready_flag <= ready_flag_next;
    end
  end

endmodule

// ----- rtl/gn_queue.sv -----
module gn_queue #(
  parameter int DEPTH = gn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gn_pkg::gn_cmd_t din,
  output logic            full,
  input  logic            pop,
  output gn_pkg::gn_cmd_t dout,
  output logic            empty
);
  import gn_pkg::*;

  // DEPTH must be a power of two so the pointers wrap by themselves; the block does not check it
  localparam int PW = $clog2(DEPTH);

  gn_cmd_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fill;

  assign full  = (fill == (PW+1)'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- rtl/gn_div.sv -----
module gn_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 45
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  // restoring divider, one quotient bit per cycle
  localparam int SW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_sh;
  logic [DEN_W:0]   rem, rem_sh, diff;
  logic [DEN_W-1:0] den_r;
  logic [SW-1:0]    steps;
  logic             busy;

  assign rem_sh = {rem[DEN_W-1:0], quo_sh[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign quo    = quo_sh;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= num;
      rem    <= '0;
      den_r  <= den;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem    <= diff;
        quo_sh <= {quo_sh[NUM_W-2:0], 1'b1};
      end else begin
        rem    <= rem_sh;
        quo_sh <= {quo_sh[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/gn_sqrt.sv -----
module gn_sqrt #(
  parameter int IN_W = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   x,
  output logic              done,
  output logic [IN_W/2-1:0] root
);
  // digit-by-digit square root, two radicand bits per cycle
  localparam int RW = IN_W / 2;
  localparam int SW = $clog2(RW + 1);

  logic [IN_W-1:0] x_sh;
  logic [RW:0]     rem;
  logic [RW-1:0]   root_r;
  logic [RW+2:0]   rem_sh, trial, diff;
  logic [SW-1:0]   steps;
  logic            busy, ge;

  assign rem_sh = {rem, x_sh[IN_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      x_sh   <= x;
      rem    <= '0;
      root_r <= '0;
    end else if (busy) begin
      rem    <= ge ? diff[RW:0] : rem_sh[RW:0];
      root_r <= {root_r[RW-2:0], ge};
      x_sh   <= {x_sh[IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(RW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/gn_back.sv -----
module gn_back #(
  parameter int MAX_GROUP_ELEMS = gn_pkg::MAX_GROUP_ELEMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gn_pkg::gn_cmd_t          head,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [gn_pkg::EPS_W-1:0] epsilon,
  input  logic                     affine_enable,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output gn_pkg::rsp_word_t        rsp_word
);
  import gn_pkg::*;

  localparam int AW    = (MAX_GROUP_ELEMS > 1) ? $clog2(MAX_GROUP_ELEMS) : 1;
  localparam int CW    = $clog2(MAX_GROUP_ELEMS + 1);
  localparam int SUM_W = SAMPLE_W + CW;
  localparam int SQ_W  = 32 + CW;
  localparam int NUM_W = (SQ_W > 49) ? SQ_W : 49;
  localparam int DEN_W = SQ_W;
  localparam int SQI_W = NUM_W + (NUM_W % 2);
  localparam int RW    = SQI_W / 2;
  localparam logic [NUM_W-1:0] INV_NUM = NUM_W'(64'h0001_0000_0000_0000);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_MEAN_GO = 16'h0002,
    S_MEAN_W  = 16'h0004,
    S_SQ      = 16'h0008,
    S_VAR_GO  = 16'h0010,
    S_VAR_W   = 16'h0020,
    S_INV_GO  = 16'h0040,
    S_INV_W   = 16'h0080,
    S_SQRT_GO = 16'h0100,
    S_SQRT_W  = 16'h0200,
    S_OFF_MUL = 16'h0400,
    S_OFF     = 16'h0800,
    S_RD_MUL  = 16'h1000,
    S_RD_AFF  = 16'h2000,
    S_RD_RND  = 16'h4000,
    S_OUT     = 16'h8000
  } state_t;

  state_t state;

  // sample store
  logic [SAMPLE_W-1:0]        store [MAX_GROUP_ELEMS];
  logic signed [SAMPLE_W-1:0] rdq;
  logic [AW-1:0]              raddr;
  logic                       mem_we;

  // group statistics
  logic signed [SUM_W-1:0]    sum, sum_base, sum_next;
  logic [SUM_W-1:0]           sum_mag;
  logic [CW-1:0]              cnt, iss;
  logic signed [SAMPLE_W-1:0] mean;
  logic [SQ_W-1:0]            sq_sum;
  logic [DEN_W-1:0]           vden, v_calc;
  logic [SCALE_W-1:0]         k;
  logic signed [OFFSET_W-1:0] off;
  logic signed [40:0]         prod;
  logic [40:0]                pmag;
  logic [40:0]                pround;
  logic [16:0]                mq, m17;

  // square pass pipeline
  logic                       v1, v2;
  logic signed [16:0]         d;
  logic signed [33:0]         dd;
  logic [31:0]                sq_r;

  // read path
  logic signed [SAMPLE_W-1:0] gamma_r, beta_r;
  logic signed [40:0]         xk;
  logic signed [41:0]         y;
  logic signed [57:0]         yg;
  logic signed [58:0]         t;
  logic [58:0]                tmag, ymag, rnd;
  logic [34:0]                rq;
  logic                       rneg;
  logic signed [SAMPLE_W-1:0] sat;
  rsp_word_t                  res;

  // shared divider and the square-root unit
  logic             div_start, div_done, sqrt_start, sqrt_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic [RW-1:0]    sq_root;

  gn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  gn_sqrt #(.IN_W(SQI_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .x(SQI_W'(div_quo)),
    .done(sqrt_done), .root(sq_root)
  );

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign mem_we = q_pop && (head.op == OP_PUSH) && !head.drop;
  assign raddr  = (state == S_SQ) ? iss[AW-1:0] : head.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) store[head.addr[AW-1:0]] <= head.sample;
    rdq <= store[raddr];
  end

  always_comb begin
    sum_base = head.new_group ? '0 : sum;
    sum_next = head.drop ? sum_base : sum_base + SUM_W'(head.sample);
    sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    mq       = div_quo[16:0];
    m17      = sum[SUM_W-1] ? 17'(-mq) : mq;
    v_calc   = DEN_W'(div_quo) + DEN_W'(epsilon);
    d        = {rdq[15], rdq} - {mean[15], mean};
    dd       = d * d;
    pmag     = prod[40] ? 41'(-prod) : 41'(prod);
    pround   = pmag + 41'd128;
    xk       = rdq * $signed({1'b0, k});
    yg       = y * gamma_r;
  end

  always_comb begin
    div_start  = 1'b0;
    sqrt_start = (state == S_SQRT_GO);
    div_num    = INV_NUM;
    div_den    = vden;
    case (state)
      S_MEAN_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(sum_mag) + NUM_W'(cnt >> 1);
        div_den   = DEN_W'(cnt);
      end
      S_VAR_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(sq_sum);
        div_den   = DEN_W'(cnt);
      end
      S_INV_GO: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  // final rounding, half away from zero, then saturation
  always_comb begin
    tmag = t[58] ? 59'(-t) : 59'(t);
    ymag = 59'(y[41] ? 42'(-y) : 42'(y));
    if (affine_enable) begin
      rneg = t[58];
      rnd  = tmag + 59'(1 << 23);
      rq   = rnd[58:24];
    end else begin
      rneg = y[41];
      rnd  = ymag + 59'(1 << 15);
      rq   = 35'(rnd[58:16]);
    end
    if (rneg) begin
      sat = (rq > 35'd32768) ? 16'sh8000 : 16'(-rq);
    end else begin
      sat = (rq > 35'd32767) ? 16'sh7fff : 16'(rq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      sum       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_OUT)) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (head.op == OP_PUSH) begin
              sum <= sum_next;
              if (head.last) begin
                cnt   <= CW'(head.count);
                state <= S_MEAN_GO;
              end
            end else begin
              gamma_r    <= head.gamma;
              beta_r     <= head.beta;
              res.value  <= '0;
              res.status <= head.status;
              state      <= (head.status == ST_OK) ? S_RD_MUL : S_OUT;
            end
          end
        end
        S_MEAN_GO: state <= S_MEAN_W;
        S_MEAN_W: begin
          if (div_done) begin
            mean   <= m17[15:0];
            iss    <= '0;
            v1     <= 1'b0;
            v2     <= 1'b0;
            sq_sum <= '0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          v1   <= (iss != cnt);
          if (iss != cnt) iss <= iss + 1'b1;
          sq_r <= dd[31:0];
          v2   <= v1;
          if (v2) sq_sum <= sq_sum + SQ_W'(sq_r);
          if ((iss == cnt) && !v1 && !v2) state <= S_VAR_GO;
        end
        S_VAR_GO: state <= S_VAR_W;
        S_VAR_W: begin
          if (div_done) begin
            vden <= v_calc;
            if (v_calc == '0) begin
              k     <= '1;
              state <= S_OFF_MUL;
            end else begin
              state <= S_INV_GO;
            end
          end
        end
        S_INV_GO: state <= S_INV_W;
        S_INV_W: if (div_done) state <= S_SQRT_GO;
        S_SQRT_GO: state <= S_SQRT_W;
        S_SQRT_W: begin
          if (sqrt_done) begin
            k     <= (|sq_root[RW-1:SCALE_W]) ? '1 : sq_root[SCALE_W-1:0];
            state <= S_OFF_MUL;
          end
        end
        S_OFF_MUL: begin
          prod  <= mean * $signed({1'b0, k});
          state <= S_OFF;
        end
        S_OFF: begin
          off   <= prod[40] ? OFFSET_W'(pround[40:8]) : OFFSET_W'(-pround[40:8]);
          state <= S_IDLE;
        end
        S_RD_MUL: begin
          y     <= {xk[40], xk} + {{2{off[31]}}, off, 8'b0};
          state <= S_RD_AFF;
        end
        S_RD_AFF: begin
          t     <= {yg[57], yg} + {{19{beta_r[15]}}, beta_r, 24'b0};
          state <= S_RD_RND;
        end
        S_RD_RND: begin
          res.value  <= sat;
          res.status <= ST_OK;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp_word  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/group_normalization.sv -----
// Group normalization of one group of signed Q8.8 samples.
// Request channel (req_valid/req_ready/req_word): op selects push or read.
//   A push stores one sample; the push marked last closes the group and
//   starts the statistics. A push after the statistics are done opens a
//   new group. Pushes past MAX_GROUP_ELEMS are dropped.
// Response channel (rsp_valid/rsp_ready/rsp_word): one word per read,
//   value in Q8.8 saturated, status ok / not ready / index out of range.
//   Pushes give no response.
// A front stage classifies each request and queues it (QUEUE_DEPTH words);
//   the back stage executes them in order, so a stalled response only
//   backs up the queue and then req_ready.
// Closing a group: the mean, variance and reciprocal each run in a shared
//   49-bit divider (one bit per cycle), the square pass reads the sample
//   RAM once per element, and the square root resolves one bit per cycle.
// A read's response passes the RAM read, two multiply stages, rounding and
//   the output register after it leaves the queue; reads are served one at
//   a time. An error response skips the arithmetic and goes straight to the
//   output register.
// Reset clears the group (empty, statistics not ready) and the registers
//   (epsilon 66, affine on); the sample RAM is not cleared.
// Registers over APB: epsilon at 0x0, affine_enable at 0x4.
module group_normalization #(
  parameter int MAX_GROUP_ELEMS = gn_pkg::MAX_GROUP_ELEMS_DEF,
  parameter int QUEUE_DEPTH     = gn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  gn_pkg::req_word_t req_word,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output gn_pkg::rsp_word_t rsp_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gn_pkg::*;

  logic [EPS_W-1:0] epsilon;
  logic             affine_enable;

  // queue hookup
  logic    q_push, q_pop, q_full, q_empty;
  gn_cmd_t q_cmd, q_head;

  // register file; the word offset is paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_AFFINE) ? {31'b0, affine_enable}
                                           : {{(32-EPS_W){1'b0}}, epsilon};

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon       <= EPS_RESET;
      affine_enable <= AFFINE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_EPSILON: epsilon       <= pwdata[EPS_W-1:0];
        REG_AFFINE:  affine_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  gn_front #(.MAX_GROUP_ELEMS(MAX_GROUP_ELEMS)) u_front (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
  );

  gn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .din(q_cmd), .full(q_full),
    .pop(q_pop), .dout(q_head), .empty(q_empty)
  );

  gn_back #(.MAX_GROUP_ELEMS(MAX_GROUP_ELEMS)) u_back (
    .clk(clk), .rst(rst),
    .head(q_head), .q_empty(q_empty), .q_pop(q_pop),
    .epsilon(epsilon), .affine_enable(affine_enable),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
  );

  // front never writes a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue overflow");

  // back never takes from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue underflow");

  // error responses carry a zero value
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_word.status != ST_OK) |-> (rsp_word.value == '0))
    else $error("error response with nonzero value");

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

// ----- test/group_normalization_tb.sv -----
`timescale 1ns / 1ps

module group_normalization_tb;
  import gn_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_word_t   req_word;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_word_t   rsp_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  group_normalization DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // words waiting to go out, and responses the group math says must come back
  req_word_t pending_words[$];
  rsp_word_t expected_rsp[$];

  // shadow of the block: sample buffer, group stats, registers
  logic signed [15:0] shadow_store [MAX_GROUP_ELEMS_DEF];
  int                 grp_count;
  longint             grp_sum;
  longint             grp_scale;
  longint             grp_offset;
  bit                 grp_ready;
  longint             eps_reg;
  bit                 affine_reg;

  int  mismatches;
  int  words_sent;
  int  rsp_seen;
  int  cyc;
  bit  req_taken;
  bit  hold_rsp;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("group_normalization test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // group arithmetic
  // ---------------------------------------------------------------------------

  // divide, rounding half away from zero; den > 0
  function automatic longint div_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // closing pass: mean, variance, 1/sqrt(var+eps), offset
  function automatic void close_group();
    longint mean;
    longint d;
    longint unsigned sq;
    longint unsigned v;
    longint unsigned k;
    if (grp_count == 0) return;
    mean = div_half_away(grp_sum, grp_count);
    sq = 0;
    for (int i = 0; i < grp_count; i++) begin
      d = longint'(shadow_store[i]) - mean;
      sq += longint'(d * d);
    end
    v = sq / grp_count + eps_reg;
    if (v == 0) begin
      k = 64'hFFFFFF;
    end else begin
      k = int_sqrt((64'h1 << 48) / v);
      if (k > 64'hFFFFFF) k = 64'hFFFFFF;
    end
    grp_scale = longint'(k);
    grp_offset = -div_half_away(mean * grp_scale, 256);
    grp_ready = 1'b1;
  endfunction

  // apply one accepted word to the shadow; queue its response, if any
  function automatic void normalize_word(req_word_t w);
    rsp_word_t r;
    longint y;
    longint v;
    if (w.op == OP_PUSH) begin
      if (grp_ready) begin
        grp_count = 0;
        grp_sum = 0;
        grp_ready = 1'b0;
      end
      if (grp_count < MAX_GROUP_ELEMS_DEF) begin
        shadow_store[grp_count] = w.sample;
        grp_sum += longint'(w.sample);
        grp_count++;
      end
      if (w.last) close_group();
      return;
    end
    r.value = '0;
    if (!grp_ready) begin
      r.status = ST_NOT_READY;
    end else if (int'(w.index) >= grp_count) begin
      r.status = ST_RANGE;
    end else begin
      r.status = ST_OK;
      y = longint'(shadow_store[w.index]) * grp_scale + grp_offset * 256;
      if (affine_reg)
        v = div_half_away(y * longint'(w.gamma) + (longint'(w.beta) <<< 24),
                          64'sd1 << 24);
      else
        v = div_half_away(y, 64'sd1 << 16);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r.value = v[15:0];
    end
    expected_rsp.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: request side, changes on falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_taken <= req_valid && req_ready;
    cyc <= rst ? 0 : cyc + 1;
  end

  // idle-free stretch
  assign calm = (cyc >= 2000) && (cyc < 4500);

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // holding until taken
    end else if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
      req_word <= pending_words.pop_front();
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= !hold_rsp && (calm || $urandom_range(99) >= 25);
  end

  // long receiver hold-off once traffic is flowing, to back the queue up
  initial begin
    hold_rsp = 1'b0;
    wait (rsp_seen >= 20);
    @(negedge clk);
    hold_rsp = 1'b1;
    repeat (400) @(posedge clk);
    hold_rsp = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accept, check on response
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) normalize_word(req_word);
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: value %0d status %0d",
                     rsp_word.value, rsp_word.status);
        end else begin
          rsp_word_t e;
          e = expected_rsp.pop_front();
          if (e.value !== rsp_word.value || e.status !== rsp_word.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       e.value, e.status, rsp_word.value, rsp_word.status);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic req_word_t push_word(logic [15:0] s, logic lst);
    req_word_t w;
    w = req_word_t'($bits(req_word_t)'({$urandom, $urandom}));
    w.op = OP_PUSH;
    w.sample = s;
    w.last = lst;
    return w;
  endfunction

  function automatic req_word_t read_word(logic [11:0] idx, logic [15:0] g, logic [15:0] b);
    req_word_t w;
    w = req_word_t'($bits(req_word_t)'({$urandom, $urandom}));
    w.op = OP_READ;
    w.index = idx;
    w.gamma = g;
    w.beta = b;
    return w;
  endfunction

  function automatic void send(req_word_t w);
    pending_words.push_back(w);
    words_sent++;
  endfunction

  task automatic apb_write(logic regsel, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {regsel, 2'b00}; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (regsel == REG_EPSILON) eps_reg = data[15:0];
    else affine_reg = data[0];
  endtask

  // let everything drain, then cover a closing pass with no response
  task automatic drain();
    wait (pending_words.size() == 0 && !req_valid);
    wait (expected_rsp.size() == 0);
    repeat (6000) @(posedge clk);
  endtask

  // one group with random contents, then reads against it
  task automatic random_group();
    int n;
    int style;
    int nreads;
    logic [15:0] base;
    logic [15:0] s;
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
    style = $urandom_range(3);
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: s = 16'($urandom);
        1: s = 16'(base + $urandom_range(0, 63) - 32);
        2: s = base;
        default: s = $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(15))
                                          : 16'(16'h8000 + $urandom_range(15));
      endcase
      // stray reads mid-group hit the not-ready path; one sent before the first push still sees the previous group
      if ($urandom_range(19) == 0)
        send(read_word(12'($urandom), 16'($urandom), 16'($urandom)));
      send(push_word(s, i == n - 1));
    end
    nreads = $urandom_range(1, 10);
    for (int i = 0; i < nreads; i++) begin
      if ($urandom_range(7) == 0)
        send(read_word(12'($urandom), 16'($urandom), 16'($urandom)));
      else
        send(read_word(12'($urandom_range(n - 1)), 16'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_word = '0;
    rsp_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; words_sent = 0; rsp_seen = 0;
    grp_count = 0; grp_sum = 0; grp_scale = 0; grp_offset = 0; grp_ready = 1'b0;
    eps_reg = EPS_RESET; affine_reg = AFFINE_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: read before any stats, extremes, range error
    send(read_word(12'd0, 16'h0100, 16'h0000));
    send(push_word(16'h7FFF, 1'b0));
    send(push_word(16'h8000, 1'b0));
    send(push_word(16'h0000, 1'b0));
    send(push_word(16'hFFFF, 1'b1));
    send(read_word(12'd0, 16'h7FFF, 16'h7FFF));
    send(read_word(12'd1, 16'h7FFF, 16'h8000));
    send(read_word(12'd2, 16'h8000, 16'h0000));
    send(read_word(12'd3, 16'h0100, 16'hFFFF));
    send(read_word(12'd4, 16'h0100, 16'h0000));
    send(read_word(12'hFFF, 16'hFFFF, 16'hFFFF));
    // new group opened by a push after stats; read before close
    send(push_word(16'h0123, 1'b0));
    send(read_word(12'd0, 16'h0100, 16'h0000));
    send(push_word(16'h0456, 1'b1));
    send(read_word(12'd1, 16'h0100, 16'h0000));
    // single-element group
    send(push_word(16'h5A5A, 1'b1));
    send(read_word(12'd0, 16'h0100, 16'h0100));
    for (int i = 0; i < 4; i++) random_group();
    drain();

    // zero variance with zero epsilon: scale saturates
    apb_write(REG_EPSILON, 32'd0);
    apb_write(REG_AFFINE, 32'd0);
    for (int i = 0; i < 4; i++) send(push_word(16'h0280, i == 3));
    send(read_word(12'd2, 16'h0000, 16'h0000));
    for (int i = 0; i < 5; i++) random_group();
    drain();

    apb_write(REG_EPSILON, 32'd65535);
    apb_write(REG_AFFINE, 32'd1);
    for (int i = 0; i < 5; i++) random_group();
    drain();

    apb_write(REG_EPSILON, 32'd65535);
    apb_write(REG_AFFINE, 32'd0);
    for (int i = 0; i < 5; i++) random_group();
    drain();

    apb_write(REG_EPSILON, 32'd66);
    apb_write(REG_AFFINE, 32'd1);
    while (words_sent < 700) random_group();
    drain();

    $display("%0d request words sent, %0d responses checked, %0d mismatches",
             words_sent, rsp_seen, mismatches);
    $display("covered: push/read, not-ready and range errors, eps and affine extremes");
    if (mismatches == 0 && expected_rsp.size() == 0)
      $display("group_normalization test passed");
    else
      $display("group_normalization test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gn_pkg.sv
rtl/gn_front.sv
rtl/gn_queue.sv
rtl/gn_div.sv
rtl/gn_sqrt.sv
rtl/gn_back.sv
rtl/group_normalization.sv
test/group_normalization_tb.sv
